/* design/ver_pkg.sv */
// shared constants and types for the vertex rotation block
`default_nettype none

package ver_pkg;

  // coordinate width default, signed Q16.8
  localparam int COORD_BITS_DEF = 24;

  // coefficient format, signed Q2.14
  localparam int COEF_BITS  = 16;
  localparam int FRAC_SHIFT = 14;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE  = 16'sd16384;
  localparam logic signed [COEF_BITS-1:0] COEF_ZERO = 16'sd0;

  // configuration register map
  localparam int NUM_REGS = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COS_Z = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIN_Z = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COS_Y = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIN_Y = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COS_X = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIN_X = 3'd5;

  // which coordinate pair a rotation unit works on
  typedef enum logic [1:0] {
    PLANE_XY,
    PLANE_XZ,
    PLANE_YZ
  } plane_t;

endpackage

`default_nettype wire

/* design/ver_channels.sv */
// valid/ready channel interfaces for vertices and configuration writes
`default_nettype none

interface ver_vtx_in_if #(
  parameter int COORD_BITS = ver_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_in;
  logic signed [COORD_BITS-1:0] y_in;
  logic signed [COORD_BITS-1:0] z_in;

  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface ver_vtx_out_if #(
  parameter int COORD_BITS = ver_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_out;
  logic signed [COORD_BITS-1:0] y_out;
  logic signed [COORD_BITS-1:0] z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

interface ver_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [ver_pkg::CFG_INDEX_BITS-1:0]         index;
  logic signed [ver_pkg::COEF_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/ver_plane_rot.sv */
// one plane rotation: product stage, then sum, round and saturate stage
`default_nettype none

module ver_plane_rot #(
  parameter int              COORD_BITS = ver_pkg::COORD_BITS_DEF,
  parameter ver_pkg::plane_t PLANE      = ver_pkg::PLANE_XY
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [ver_pkg::COEF_BITS-1:0] cos_c,
  input  wire logic signed [ver_pkg::COEF_BITS-1:0] sin_c,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [COORD_BITS-1:0]        in_x,
  input  wire logic signed [COORD_BITS-1:0]        in_y,
  input  wire logic signed [COORD_BITS-1:0]        in_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [COORD_BITS-1:0]             out_x,
  output logic signed [COORD_BITS-1:0]             out_y,
  output logic signed [COORD_BITS-1:0]             out_z
);

  localparam int PROD_W = COORD_BITS + ver_pkg::COEF_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - ver_pkg::FRAC_SHIFT;
  localparam logic signed [SUM_W-1:0] ROUND_HALF =
    SUM_W'(1) <<< (ver_pkg::FRAC_SHIFT - 1);

  // saturate a rounded value to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [Q_W-1:0] q);
    logic [Q_W-COORD_BITS:0] hi;
    hi = q[Q_W-1:COORD_BITS-1];
    if ((&hi) || !(|hi)) begin
      return q[COORD_BITS-1:0];
    end else if (q[Q_W-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  logic signed [COORD_BITS-1:0] a_in, b_in, c_in;
  logic                         adv1, adv2;

  // stage 1: four products plus the untouched coordinate
  logic                         v1;
  logic signed [PROD_W-1:0]     p_ac, p_bs, p_as, p_bc;
  logic signed [COORD_BITS-1:0] c1;

  // stage 2: rotated pair
  logic                         v2;
  logic signed [COORD_BITS-1:0] a2, b2, c2;

  logic signed [SUM_W-1:0]      sum_a, sum_b;

  always_comb begin
    case (PLANE)
      ver_pkg::PLANE_XZ: begin
        a_in = in_x; b_in = in_z; c_in = in_y;
      end
      ver_pkg::PLANE_YZ: begin
        a_in = in_y; b_in = in_z; c_in = in_x;
      end
      default: begin
        a_in = in_x; b_in = in_y; c_in = in_z;
      end
    endcase
  end

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign sum_a = SUM_W'(p_ac) - SUM_W'(p_bs) + ROUND_HALF;
  assign sum_b = SUM_W'(p_as) + SUM_W'(p_bc) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
    if (adv1 && in_valid) begin
      p_ac <= PROD_W'(a_in) * PROD_W'(cos_c);
      p_bs <= PROD_W'(b_in) * PROD_W'(sin_c);
      p_as <= PROD_W'(a_in) * PROD_W'(sin_c);
      p_bc <= PROD_W'(b_in) * PROD_W'(cos_c);
      c1   <= c_in;
    end
    if (adv2 && v1) begin
      a2 <= sat(sum_a[SUM_W-1:ver_pkg::FRAC_SHIFT]);
      b2 <= sat(sum_b[SUM_W-1:ver_pkg::FRAC_SHIFT]);
      c2 <= c1;
    end
  end

  always_comb begin
    case (PLANE)
      ver_pkg::PLANE_XZ: begin
        out_x = a2; out_z = b2; out_y = c2;
      end
      ver_pkg::PLANE_YZ: begin
        out_y = a2; out_z = b2; out_x = c2;
      end
      default: begin
        out_x = a2; out_y = b2; out_z = c2;
      end
    endcase
  end

  assign out_valid = v2;

  // both stages come up empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !v1 && !v2)
    else $error("rotation stages not empty after reset");

  // an empty slot anywhere means the unit takes a new transaction
  a_no_lockup: assert property (@(posedge clk) disable iff (rst)
    (!v1 || !v2) |-> in_ready)
    else $error("rotation unit refuses input with a free stage");

  // products held while the second stage is blocked
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv2) |=> (v1 && $stable(p_ac) && $stable(p_bc) && $stable(c1)))
    else $error("product stage lost data under stall");

endmodule

`default_nettype wire

/* design/vertex_euler_rotation.sv */
// top level: coefficient registers and three chained plane rotation units
`default_nettype none

// Rotates one vertex (signed Q16.8) by three angles, each given as a Q2.14
// cosine/sine pair written through the configuration channel (reset gives
// the identity). The rotations run (x,y) by the z pair, then (x,z) by the y
// pair, then (y,z) by the x pair; each rounds to nearest and saturates to
// the coordinate range. The block takes one vertex transaction per clock
// unless back-pressure from the output has filled the pipeline: every
// rotation unit has a multiply stage and a sum/round/saturate stage, six
// register stages in all, the first loaded at the accepting edge. Ready is
// computed stage by stage, so bubbles are squeezed out and the input keeps
// flowing while a finished result waits at the output, until all six stages
// hold a vertex. Coefficients are read live by the pipeline and must only be
// written while no vertex is in flight.

module vertex_euler_rotation #(
  parameter int COORD_BITS = ver_pkg::COORD_BITS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  ver_vtx_in_if.sink     vtx_in,
  ver_vtx_out_if.source  vtx_out,
  ver_cfg_if.sink        cfg
);

  // coefficient registers, indexed by the register map
  logic signed [ver_pkg::COEF_BITS-1:0] coef [ver_pkg::NUM_REGS];

  // handshake and coordinates between the rotation units
  logic                         v_zy, r_zy, v_yx, r_yx;
  logic signed [COORD_BITS-1:0] x_zy, y_zy, z_zy;
  logic signed [COORD_BITS-1:0] x_yx, y_yx, z_yx;

  // configuration writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[ver_pkg::REG_COS_Z] <= ver_pkg::COEF_ONE;
      coef[ver_pkg::REG_SIN_Z] <= ver_pkg::COEF_ZERO;
      coef[ver_pkg::REG_COS_Y] <= ver_pkg::COEF_ONE;
      coef[ver_pkg::REG_SIN_Y] <= ver_pkg::COEF_ZERO;
      coef[ver_pkg::REG_COS_X] <= ver_pkg::COEF_ONE;
      coef[ver_pkg::REG_SIN_X] <= ver_pkg::COEF_ZERO;
    end else if (cfg.valid) begin
      case (cfg.index)
        ver_pkg::REG_COS_Z: coef[ver_pkg::REG_COS_Z] <= cfg.data;
        ver_pkg::REG_SIN_Z: coef[ver_pkg::REG_SIN_Z] <= cfg.data;
        ver_pkg::REG_COS_Y: coef[ver_pkg::REG_COS_Y] <= cfg.data;
        ver_pkg::REG_SIN_Y: coef[ver_pkg::REG_SIN_Y] <= cfg.data;
        ver_pkg::REG_COS_X: coef[ver_pkg::REG_COS_X] <= cfg.data;
        ver_pkg::REG_SIN_X: coef[ver_pkg::REG_SIN_X] <= cfg.data;
        default: ;
      endcase
    end
  end

  // first rotation: x,y plane about z
  ver_plane_rot #(
    .COORD_BITS (COORD_BITS),
    .PLANE      (ver_pkg::PLANE_XY)
  ) u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .cos_c     (coef[ver_pkg::REG_COS_Z]),
    .sin_c     (coef[ver_pkg::REG_SIN_Z]),
    .in_valid  (vtx_in.valid),
    .in_ready  (vtx_in.ready),
    .in_x      (vtx_in.x_in),
    .in_y      (vtx_in.y_in),
    .in_z      (vtx_in.z_in),
    .out_valid (v_zy),
    .out_ready (r_zy),
    .out_x     (x_zy),
    .out_y     (y_zy),
    .out_z     (z_zy)
  );

  // second rotation: x,z plane about y
  ver_plane_rot #(
    .COORD_BITS (COORD_BITS),
    .PLANE      (ver_pkg::PLANE_XZ)
  ) u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .cos_c     (coef[ver_pkg::REG_COS_Y]),
    .sin_c     (coef[ver_pkg::REG_SIN_Y]),
    .in_valid  (v_zy),
    .in_ready  (r_zy),
    .in_x      (x_zy),
    .in_y      (y_zy),
    .in_z      (z_zy),
    .out_valid (v_yx),
    .out_ready (r_yx),
    .out_x     (x_yx),
    .out_y     (y_yx),
    .out_z     (z_yx)
  );

  // third rotation: y,z plane about x, feeds the output channel directly
  ver_plane_rot #(
    .COORD_BITS (COORD_BITS),
    .PLANE      (ver_pkg::PLANE_YZ)
  ) u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .cos_c     (coef[ver_pkg::REG_COS_X]),
    .sin_c     (coef[ver_pkg::REG_SIN_X]),
    .in_valid  (v_yx),
    .in_ready  (r_yx),
    .in_x      (x_yx),
    .in_y      (y_yx),
    .in_z      (z_yx),
    .out_valid (vtx_out.valid),
    .out_ready (vtx_out.ready),
    .out_x     (vtx_out.x_out),
    .out_y     (vtx_out.y_out),
    .out_z     (vtx_out.z_out)
  );

endmodule

`default_nettype wire

/* dv/vertex_euler_rotation_check.sv */
// watches the vertex channels, predicts each rotated vertex and compares the results

module vertex_euler_rotation_check #(
  parameter int COORD_BITS = ver_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ver_vtx_in_if      vtx_in,
  ver_vtx_out_if     vtx_out,
  ver_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef logic signed [COORD_BITS-1:0]         coord_t;
  typedef logic signed [ver_pkg::COEF_BITS-1:0] coef_t;
  typedef logic signed [127:0]                  wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  localparam wide_t COORD_HI  = (wide_t'(1) <<< (COORD_BITS - 1)) - wide_t'(1);
  localparam wide_t COORD_LO  = -COORD_HI - wide_t'(1);
  localparam wide_t HALF_LSB  = wide_t'(1) <<< (ver_pkg::FRAC_SHIFT - 1);

  coef_t cos_z, sin_z, cos_y, sin_y, cos_x, sin_x;

  vertex_t     rotated_q[$];
  int unsigned miss_count = 0;
  int unsigned result_count = 0;

  assign mismatches = miss_count;

  // exact Q.22 sum, round half up, back to Q16.8, clamp to the coordinate range
  function automatic coord_t round_to_coord(input wide_t acc);
    wide_t q;
    q = (acc + HALF_LSB) >>> ver_pkg::FRAC_SHIFT;
    if (q > COORD_HI) q = COORD_HI;
    if (q < COORD_LO) q = COORD_LO;
    return coord_t'(q);
  endfunction

  function automatic void turn_plane(inout coord_t a, inout coord_t b,
                                     input coef_t c, input coef_t s);
    coord_t na;
    na = round_to_coord(wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(s));
    b  = round_to_coord(wide_t'(a) * wide_t'(s) + wide_t'(b) * wide_t'(c));
    a  = na;
  endfunction

  function automatic vertex_t rotate_vertex(input coord_t xi, input coord_t yi,
                                            input coord_t zi);
    coord_t x, y, z;
    x = xi;
    y = yi;
    z = zi;
    turn_plane(x, y, cos_z, sin_z);
    turn_plane(x, z, cos_y, sin_y);
    turn_plane(y, z, cos_x, sin_x);
    return '{x: x, y: y, z: z};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    miss_count++;
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      rotated_q.delete();
      cos_z = ver_pkg::COEF_ONE;
      sin_z = ver_pkg::COEF_ZERO;
      cos_y = ver_pkg::COEF_ONE;
      sin_y = ver_pkg::COEF_ZERO;
      cos_x = ver_pkg::COEF_ONE;
      sin_x = ver_pkg::COEF_ZERO;
    end else begin
      if (vtx_out.valid && vtx_out.ready) begin
        if (rotated_q.size() == 0) begin
          flag_mismatch("result with no vertex in flight");
        end else begin
          want = rotated_q.pop_front();
          if (vtx_out.x_out !== want.x)
            flag_mismatch($sformatf("x_out %0d, predicted %0d", vtx_out.x_out, want.x));
          if (vtx_out.y_out !== want.y)
            flag_mismatch($sformatf("y_out %0d, predicted %0d", vtx_out.y_out, want.y));
          if (vtx_out.z_out !== want.z)
            flag_mismatch($sformatf("z_out %0d, predicted %0d", vtx_out.z_out, want.z));
        end
        result_count++;
      end
      if (vtx_in.valid && vtx_in.ready)
        rotated_q.insert(rotated_q.size(),
                         rotate_vertex(vtx_in.x_in, vtx_in.y_in, vtx_in.z_in));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          ver_pkg::REG_COS_Z: cos_z = cfg.data;
          ver_pkg::REG_SIN_Z: sin_z = cfg.data;
          ver_pkg::REG_COS_Y: cos_y = cfg.data;
          ver_pkg::REG_SIN_Y: sin_y = cfg.data;
          ver_pkg::REG_COS_X: cos_x = cfg.data;
          ver_pkg::REG_SIN_X: sin_x = cfg.data;
          default: ;
        endcase
      end
    end
    outstanding <= rotated_q.size();
  end

endmodule

/* dv/vertex_euler_rotation_test.sv */
// stimulus and verdict for the three-angle vertex rotation block

module vertex_euler_rotation_test;

  localparam int CB = ver_pkg::COORD_BITS_DEF;

  typedef logic signed [CB-1:0]                 coord_t;
  typedef logic signed [ver_pkg::COEF_BITS-1:0] coef_t;
  typedef logic [ver_pkg::CFG_INDEX_BITS-1:0]   cfg_index_t;

  // how the cosine/sine pairs of a batch are picked
  typedef enum logic [1:0] {
    STYLE_UNIT,   // true angles, a proper rotation
    STYLE_SPAN,   // each value anywhere in -1.0 .. +1.0
    STYLE_RAW,    // any 16-bit pattern
    STYLE_EDGE    // +-1.0, +-0.5 and zero mixed
  } coef_style_t;

  // indexes past the register map, the block must ignore them
  localparam cfg_index_t REG_SPARE_LO = 3'd6;
  localparam cfg_index_t REG_SPARE_HI = 3'd7;

  localparam coord_t CMAX = coord_t'((longint'(1) <<< (CB - 1)) - 1);
  localparam coord_t CMIN = ~CMAX;

  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 300;   // receiver hold-off, far deeper than the pipeline
  localparam int DRAIN_CYCLES = 16;    // leave room for stray results
  localparam int QUIET_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int BATCH_ITEMS  = 220;

  logic clk = 1'b0;
  logic rst;

  // stimulus knobs, written by the main sequence only
  logic calm;       // no idling on either side
  logic hold_req;   // ask the receiver for its one long hold-off

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet = 0;
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;

  ver_vtx_in_if  #(.COORD_BITS(CB)) vtx_in ();
  ver_vtx_out_if #(.COORD_BITS(CB)) vtx_out ();
  ver_cfg_if                        cfg ();

  vertex_euler_rotation #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst     (rst),
    .vtx_in  (vtx_in),
    .vtx_out (vtx_out),
    .cfg     (cfg)
  );

  vertex_euler_rotation_check #(.COORD_BITS(CB)) rotation_check (
    .clk         (clk),
    .rst         (rst),
    .vtx_in      (vtx_in),
    .vtx_out     (vtx_out),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // result side: random stalls, one long hold-off on request, none while calm
  initial begin
    vtx_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        vtx_out.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        vtx_out.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        vtx_out.ready <= 1'b0;
      end else begin
        vtx_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: any transaction on any channel clears the count
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((vtx_in.valid && vtx_in.ready) || (vtx_out.valid && vtx_out.ready) ||
                 (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("vertex_euler_rotation_test failed");
    $finish;
  end

  // one vertex transaction; valid stays high on return so back-to-back items flow
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      vtx_in.valid <= 1'b0;
      @(posedge clk);
    end
    vtx_in.valid <= 1'b1;
    vtx_in.x_in  <= x;
    vtx_in.y_in  <= y;
    vtx_in.z_in  <= z;
    @(posedge clk);
    while (!vtx_in.ready) @(posedge clk);
  endtask

  // stop offering, wait for every predicted vertex, then let the pipe run dry
  task automatic settle();
    vtx_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input coef_t value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // all six coefficients, plus a write to an unmapped index that must change nothing
  task automatic write_rotation(input coef_t cz, input coef_t sz, input coef_t cy,
                                input coef_t sy, input coef_t cx, input coef_t sx);
    write_reg(ver_pkg::REG_COS_Z, cz);
    write_reg(ver_pkg::REG_SIN_Z, sz);
    write_reg(ver_pkg::REG_COS_Y, cy);
    write_reg(ver_pkg::REG_SIN_Y, sy);
    write_reg(ver_pkg::REG_COS_X, cx);
    write_reg(ver_pkg::REG_SIN_X, sx);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, coef_t'($urandom));
  endtask

  function automatic coef_t edge_coef();
    case ($urandom_range(4))
      0: return ver_pkg::COEF_ONE;
      1: return -ver_pkg::COEF_ONE;
      2: return 16'sd8192;
      3: return -16'sd8192;
      default: return ver_pkg::COEF_ZERO;
    endcase
  endfunction

  // one cosine/sine pair in the given style
  task automatic pick_pair(input coef_style_t style, output coef_t c, output coef_t s);
    real ang, cv, sv;
    case (style)
      STYLE_UNIT: begin
        ang = $urandom_range(35999) * 3.14159265358979 / 18000.0;
        cv  = $cos(ang) * 16384.0;
        sv  = $sin(ang) * 16384.0;
        c   = coef_t'($rtoi(cv + ((cv >= 0.0) ? 0.5 : -0.5)));
        s   = coef_t'($rtoi(sv + ((sv >= 0.0) ? 0.5 : -0.5)));
      end
      STYLE_SPAN: begin
        c = coef_t'(int'($urandom_range(32768)) - 16384);
        s = coef_t'(int'($urandom_range(32768)) - 16384);
      end
      STYLE_RAW: begin
        c = coef_t'($urandom);
        s = coef_t'($urandom);
      end
      default: begin
        c = edge_coef();
        s = edge_coef();
      end
    endcase
  endtask

  // mostly full-width noise and moderate values, some corner coordinates
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return coord_t'({$urandom, $urandom});
    if (pick < 80) return coord_t'(int'($urandom_range(131071)) - 65536);
    case ($urandom_range(5))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return coord_t'(1);
      4: return coord_t'(-1);
      default: return CMIN + coord_t'(1);
    endcase
  endfunction

  // corner vertices; (1,-1,2) lands on exact rounding ties at half-angle settings
  task automatic send_corners();
    send_vertex('0, '0, '0);
    send_vertex(CMAX, CMAX, CMAX);
    send_vertex(CMIN, CMIN, CMIN);
    send_vertex(CMAX, CMIN, '0);
    send_vertex(coord_t'(1), coord_t'(-1), coord_t'(2));
    send_vertex(CMIN, CMAX, coord_t'(-1));
  endtask

  // new angles while idle, then a stream of random vertices
  task automatic run_batch(input int count, input coef_style_t style,
                           input bit squeeze, input bit pause_mid);
    coef_t cz, sz, cy, sy, cx, sx;
    pick_pair(style, cz, sz);
    pick_pair(style, cy, sy);
    pick_pair(style, cx, sx);
    write_rotation(cz, sz, cy, sy, cx, sx);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // receiver holds off while we keep offering, so the input backs up
        if (squeeze) hold_req <= 1'b1;
        // sender goes quiet until every result is back
        if (pause_mid) settle();
      end
      send_vertex(rand_coord(), rand_coord(), rand_coord());
    end
    settle();
  endtask

  initial begin
    rst           <= 1'b1;
    calm          <= 1'b0;
    hold_req      <= 1'b0;
    vtx_in.valid  <= 1'b0;
    vtx_in.x_in   <= '0;
    vtx_in.y_in   <= '0;
    vtx_in.z_in   <= '0;
    cfg.valid     <= 1'b0;
    cfg.index     <= ver_pkg::REG_COS_Z;
    cfg.data      <= ver_pkg::COEF_ZERO;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity straight out of reset
    send_corners();
    settle();

    // half-angle coefficients put results on rounding ties
    write_rotation(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_corners();
    settle();

    // full-scale cosine and sine of opposite sign
    write_rotation(-ver_pkg::COEF_ONE, ver_pkg::COEF_ONE, -ver_pkg::COEF_ONE,
                   ver_pkg::COEF_ONE, -ver_pkg::COEF_ONE, ver_pkg::COEF_ONE);
    send_corners();
    settle();

    // extreme 16-bit patterns, well past +-1.0, drive saturation
    write_rotation(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_corners();
    settle();

    // long stretch with no idling on either side
    calm <= 1'b1;
    run_batch(BATCH_ITEMS, STYLE_UNIT, 1'b0, 1'b0);
    calm <= 1'b0;

    run_batch(BATCH_ITEMS, STYLE_UNIT, 1'b1, 1'b0);
    run_batch(BATCH_ITEMS, STYLE_SPAN, 1'b0, 1'b0);
    run_batch(BATCH_ITEMS, STYLE_UNIT, 1'b0, 1'b0);
    run_batch(BATCH_ITEMS, STYLE_RAW, 1'b0, 1'b0);
    run_batch(BATCH_ITEMS, STYLE_UNIT, 1'b0, 1'b1);
    run_batch(BATCH_ITEMS, STYLE_EDGE, 1'b0, 1'b0);
    run_batch(BATCH_ITEMS, STYLE_UNIT, 1'b0, 1'b0);

    if (mismatches == 0 && outstanding == 0) begin
      $display("vertex_euler_rotation_test passed");
    end else begin
      $display("vertex_euler_rotation_test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ver_pkg.sv
design/ver_channels.sv
design/ver_plane_rot.sv
design/vertex_euler_rotation.sv
dv/vertex_euler_rotation_check.sv
dv/vertex_euler_rotation_test.sv
